// File: hdl/dtca_pkg.sv
// Package for the degree trig calculator ALU: operation and status codes,
// angle constants, the CORDIC arctangent table and the pipeline sideband type.
// No dependencies.
package dtca_pkg;

  // Operation codes
  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_SIN = 4'd4;
  localparam logic [3:0] OP_COS = 4'd5;
  localparam logic [3:0] OP_TAN = 4'd6;
  localparam logic [3:0] OP_COT = 4'd7;
  localparam logic [3:0] OP_SEC = 4'd8;
  localparam logic [3:0] OP_CSC = 4'd9;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDEF = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // pi in Q4.60
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  // (3.1416 / 180) in Q0.32, rounded
  localparam logic [26:0] DEG_TO_RAD = 27'd74961496;
  // pi/2 in Q2.30 as the reduced-angle compare value
  localparam logic [31:0] RIGHT_Q30 = 32'(PI_Q60 >> 31);

  // CORDIC x/y/z datapath width
  localparam int XY_W = 34;

  // atan(2^-i) in Q2.30, rounded
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,
    32'd64,        32'd32,        32'd16,        32'd8,
    32'd4,         32'd2,         32'd1,         32'd1
  };

  // Sideband that rides along the whole pipeline
  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] a;      // operand a, later cordic x
    logic [31:0] b;      // operand b, later cordic y
    logic [31:0] val;    // result of add/sub/mul/unknown
    logic [1:0]  st;     // status of add/sub/mul/unknown
    logic        aneg;   // angle sign
    logic        flip;   // angle folded past pi/2
    logic        zero;   // reduced angle is zero
    logic        right;  // reduced angle is pi/2
    logic        qneg;   // quotient negative
    logic        dz;     // divisor zero
  } side_t;

endpackage

// File: hdl/degree_trig_calculator_alu.sv
// Fixed-point calculator ALU: add, sub, mul, div and sin/cos/tan/cot/sec/cosec of an angle
// in degrees, all in signed Q16.16 (FRAC_BITS fractional bits). Every request walks one
// fixed pipeline: input register, arithmetic and angle scaling, a chain of 25-FRAC_BITS
// modulo-2*pi cells, quadrant folding, CORDIC_STAGES rotation cells, squaring, 32 square
// root cells, divisor selection, 32+FRAC_BITS divider cells and the output register.
// Every operation takes the same path; one word is taken per cycle while no result waits
// at the output. The whole pipeline holds while a result waits at the output, and the
// input register still takes a word if empty.
// Status: 0 ok, 1 undefined (zero divisor or unknown operation, result 0), 2 saturated.
// Depends on dtca_pkg and the dtca cell modules.
module degree_trig_calculator_alu #(
  parameter int CORDIC_STAGES = 20,
  parameter int FRAC_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
  input  logic [3:0]  s_tuser,   // req_type [3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // result_value [31:0]
  output logic [1:0]  m_tuser    // status_code [1:0]
);
  import dtca_pkg::*;

  localparam int NRED = 25 - FRAC_BITS;
  localparam int QW   = 32 + FRAC_BITS;
  localparam int ZSH  = FRAC_BITS + 2;
  localparam logic [63:0] PI_Q   = PI_Q60 >> (28 - FRAC_BITS);
  localparam logic [63:0] TWO_Q  = PI_Q << 1;
  localparam logic [63:0] HALF_Q = PI_Q >> 1;
  localparam logic signed [XY_W-1:0] X0 = XY_W'(64'd1 << 30);
  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;

  logic adv;
  logic o_vld;
  logic [31:0] o_val;
  logic [1:0]  o_st;

  // pipeline moves when output is free or being taken
  assign adv      = !o_vld || m_tready;
  logic s0_vld;
  assign s_tready = !rst && (adv || !s0_vld);

  // input register
  logic [3:0]  s0_op;
  logic [31:0] s0_a, s0_b;
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (s_tready) begin
      s0_vld <= s_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (s_tready) begin
      s0_op <= s_tuser;
      s0_a  <= s_tdata[31:0];
      s0_b  <= s_tdata[63:32];
    end
  end

  // stage 1: add/sub with saturation, angle magnitude
  logic        s1_vld;
  side_t       s1_side;
  logic [31:0] s1_mag;
  logic [32:0] s1_sum, s1_dif;
  assign s1_sum = {s0_a[31], s0_a} + {s0_b[31], s0_b};
  assign s1_dif = {s0_a[31], s0_a} - {s0_b[31], s0_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= s0_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side       <= '0;
      s1_side.op    <= s0_op;
      s1_side.a     <= s0_a;
      s1_side.b     <= s0_b;
      s1_side.aneg  <= s0_a[31];
      s1_mag        <= s0_a[31] ? (32'd0 - s0_a) : s0_a;
      case (s0_op)
        OP_ADD: begin
          if (s1_sum[32] != s1_sum[31]) begin
            s1_side.val <= s1_sum[32] ? INT_MIN : INT_MAX;
            s1_side.st  <= ST_SAT;
          end else begin
            s1_side.val <= s1_sum[31:0];
            s1_side.st  <= ST_OK;
          end
        end
        OP_SUB: begin
          if (s1_dif[32] != s1_dif[31]) begin
            s1_side.val <= s1_dif[32] ? INT_MIN : INT_MAX;
            s1_side.st  <= ST_SAT;
          end else begin
            s1_side.val <= s1_dif[31:0];
            s1_side.st  <= ST_OK;
          end
        end
        OP_MUL, OP_DIV, OP_SIN, OP_COS, OP_TAN, OP_COT, OP_SEC, OP_CSC: begin
          s1_side.val <= '0;
          s1_side.st  <= ST_OK;
        end
        default: begin
          s1_side.val <= '0;
          s1_side.st  <= ST_UNDEF;
        end
      endcase
    end
  end

  // stage 2: product and degrees-to-radians scaling
  logic               s2_vld;
  side_t              s2_side;
  logic signed [63:0] s2_prod;
  logic [63:0]        s2_m;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side <= s1_side;
      s2_prod <= $signed(s1_side.a) * $signed(s1_side.b);
      s2_m    <= {32'd0, s1_mag} * {37'd0, DEG_TO_RAD};
    end
  end

  // stage 3: product scaling and saturation
  logic               s3_vld;
  side_t              s3_side;
  logic [63:0]        s3_m;
  logic signed [63:0] s3_p;
  assign s3_p = s2_prod >>> FRAC_BITS;
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side <= s2_side;
      s3_m    <= s2_m;
      if (s2_side.op == OP_MUL) begin
        if (s3_p[63:31] != '0 && s3_p[63:31] != '1) begin
          s3_side.val <= s3_p[63] ? INT_MIN : INT_MAX;
          s3_side.st  <= ST_SAT;
        end else begin
          s3_side.val <= s3_p[31:0];
          s3_side.st  <= ST_OK;
        end
      end
    end
  end

  // modulo 2*pi chain
  logic        red_vld  [NRED+1];
  side_t       red_side [NRED+1];
  logic [63:0] red_m    [NRED+1];
  assign red_vld[0]  = s3_vld;
  assign red_side[0] = s3_side;
  assign red_m[0]    = s3_m;

  for (genvar k = 0; k < NRED; k++) begin : g_red
    dtca_mod_cell #(
      .SUB(TWO_Q << (NRED - 1 - k))
    ) u_mod (
      .clk(clk), .rst(rst), .en(adv),
      .vld_in(red_vld[k]), .side_in(red_side[k]), .m_in(red_m[k]),
      .vld_out(red_vld[k+1]), .side_out(red_side[k+1]), .m_out(red_m[k+1])
    );
  end

  // fold into [0, pi]
  logic        f1_vld;
  side_t       f1_side;
  logic [63:0] f1_m;
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
    end else if (adv) begin
      f1_vld <= red_vld[NRED];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      f1_side <= red_side[NRED];
      if (red_m[NRED] > PI_Q) begin
        f1_m         <= TWO_Q - red_m[NRED];
        f1_side.aneg <= !red_side[NRED].aneg;
      end else begin
        f1_m <= red_m[NRED];
      end
    end
  end

  // fold into [0, pi/2]
  logic        f2_vld;
  side_t       f2_side;
  logic [63:0] f2_m;
  always_ff @(posedge clk) begin
    if (rst) begin
      f2_vld <= 1'b0;
    end else if (adv) begin
      f2_vld <= f1_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      f2_side <= f1_side;
      if (f1_m > HALF_Q) begin
        f2_m         <= PI_Q - f1_m;
        f2_side.aneg <= !f1_side.aneg;
        f2_side.flip <= 1'b1;
      end else begin
        f2_m <= f1_m;
      end
    end
  end

  // Q2.30 start angle and special-angle flags
  logic                   zs_vld;
  side_t                  zs_side;
  logic signed [XY_W-1:0] zs_z;
  logic [63:0]            zs_mz;
  assign zs_mz = f2_m >> ZSH;
  always_ff @(posedge clk) begin
    if (rst) begin
      zs_vld <= 1'b0;
    end else if (adv) begin
      zs_vld <= f2_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      zs_side       <= f2_side;
      zs_side.zero  <= (zs_mz == 64'd0);
      zs_side.right <= (zs_mz == {32'd0, RIGHT_Q30});
      zs_z          <= f2_side.aneg ? XY_W'(64'd0 - zs_mz) : XY_W'(zs_mz);
    end
  end

  // CORDIC chain
  logic                   rot_vld  [CORDIC_STAGES+1];
  side_t                  rot_side [CORDIC_STAGES+1];
  logic signed [XY_W-1:0] rot_x    [CORDIC_STAGES+1];
  logic signed [XY_W-1:0] rot_y    [CORDIC_STAGES+1];
  logic signed [XY_W-1:0] rot_z    [CORDIC_STAGES+1];
  assign rot_vld[0]  = zs_vld;
  assign rot_side[0] = zs_side;
  assign rot_x[0]    = X0;
  assign rot_y[0]    = '0;
  assign rot_z[0]    = zs_z;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    dtca_rot_cell #(
      .IDX(i)
    ) u_rot (
      .clk(clk), .rst(rst), .en(adv),
      .vld_in(rot_vld[i]), .side_in(rot_side[i]),
      .x_in(rot_x[i]), .y_in(rot_y[i]), .z_in(rot_z[i]),
      .vld_out(rot_vld[i+1]), .side_out(rot_side[i+1]),
      .x_out(rot_x[i+1]), .y_out(rot_y[i+1]), .z_out(rot_z[i+1])
    );
  end

  // special angles and quadrant flip; trig x/y replace the operands
  logic                   po_vld;
  side_t                  po_side;
  logic signed [XY_W-1:0] po_x, po_y;
  assign po_x = rot_side[CORDIC_STAGES].right ? '0 : rot_x[CORDIC_STAGES];
  assign po_y = rot_side[CORDIC_STAGES].zero  ? '0 : rot_y[CORDIC_STAGES];
  always_ff @(posedge clk) begin
    if (rst) begin
      po_vld <= 1'b0;
    end else if (adv) begin
      po_vld <= rot_vld[CORDIC_STAGES];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      po_side <= rot_side[CORDIC_STAGES];
      if (rot_side[CORDIC_STAGES].op >= OP_SIN && rot_side[CORDIC_STAGES].op <= OP_CSC) begin
        if (rot_side[CORDIC_STAGES].flip) begin
          po_side.a <= po_x[31:0] ^ 32'hFFFF_FFFF;
          po_side.b <= po_y[31:0] ^ 32'hFFFF_FFFF;
        end else begin
          po_side.a <= po_x[31:0];
          po_side.b <= po_y[31:0];
        end
      end
    end
  end

  // two's complement negate finish for the flip (add one)
  logic  pf_vld;
  side_t pf_side;
  always_ff @(posedge clk) begin
    if (rst) begin
      pf_vld <= 1'b0;
    end else if (adv) begin
      pf_vld <= po_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pf_side <= po_side;
      if (po_side.flip && po_side.op >= OP_SIN && po_side.op <= OP_CSC) begin
        pf_side.a <= po_side.a + 32'd1;
        pf_side.b <= po_side.b + 32'd1;
      end
    end
  end

  // magnitudes
  logic        mg_vld;
  side_t       mg_side;
  logic [31:0] mg_x, mg_y;
  always_ff @(posedge clk) begin
    if (rst) begin
      mg_vld <= 1'b0;
    end else if (adv) begin
      mg_vld <= pf_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      mg_side <= pf_side;
      mg_x    <= pf_side.a[31] ? (32'd0 - pf_side.a) : pf_side.a;
      mg_y    <= pf_side.b[31] ? (32'd0 - pf_side.b) : pf_side.b;
    end
  end

  // squares
  logic        sq_vld;
  side_t       sq_side;
  logic [63:0] sq_x, sq_y;
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
    end else if (adv) begin
      sq_vld <= mg_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side <= mg_side;
      sq_x    <= {32'd0, mg_x} * {32'd0, mg_x};
      sq_y    <= {32'd0, mg_y} * {32'd0, mg_y};
    end
  end

  // square root chain
  logic        rt_vld  [33];
  side_t       rt_side [33];
  logic [63:0] rt_v    [33];
  logic [63:0] rt_res  [33];
  always_ff @(posedge clk) begin
    if (rst) begin
      rt_vld[0] <= 1'b0;
    end else if (adv) begin
      rt_vld[0] <= sq_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      rt_side[0] <= sq_side;
      rt_v[0]    <= sq_x + sq_y;
    end
  end
  assign rt_res[0] = '0;

  for (genvar j = 0; j < 32; j++) begin : g_rt
    dtca_sqrt_cell #(
      .J(j)
    ) u_sqrt (
      .clk(clk), .rst(rst), .en(adv),
      .vld_in(rt_vld[j]), .side_in(rt_side[j]),
      .v_in(rt_v[j]), .res_in(rt_res[j]),
      .vld_out(rt_vld[j+1]), .side_out(rt_side[j+1]),
      .v_out(rt_v[j+1]), .res_out(rt_res[j+1])
    );
  end

  // pick numerator and divisor
  side_t              sl_in;
  logic [32:0]        sl_r;
  logic signed [32:0] sl_num, sl_den;
  logic [32:0]        sl_nmag, sl_dmag;
  assign sl_in = rt_side[32];
  assign sl_r  = {1'b0, rt_res[32][31:0]};

  always_comb begin
    case (sl_in.op)
      OP_DIV: begin
        sl_num = {sl_in.a[31], sl_in.a};
        sl_den = {sl_in.b[31], sl_in.b};
      end
      OP_SIN: begin
        sl_num = {sl_in.b[31], sl_in.b};
        sl_den = sl_r;
      end
      OP_COS: begin
        sl_num = {sl_in.a[31], sl_in.a};
        sl_den = sl_r;
      end
      OP_TAN: begin
        sl_num = {sl_in.b[31], sl_in.b};
        sl_den = {sl_in.a[31], sl_in.a};
      end
      OP_COT: begin
        sl_num = {sl_in.a[31], sl_in.a};
        sl_den = {sl_in.b[31], sl_in.b};
      end
      OP_SEC: begin
        sl_num = sl_r;
        sl_den = {sl_in.a[31], sl_in.a};
      end
      OP_CSC: begin
        sl_num = sl_r;
        sl_den = {sl_in.b[31], sl_in.b};
      end
      default: begin
        sl_num = '0;
        sl_den = 33'sd1;
      end
    endcase
  end
  assign sl_nmag = sl_num[32] ? (33'd0 - sl_num) : sl_num;
  assign sl_dmag = sl_den[32] ? (33'd0 - sl_den) : sl_den;

  logic          dv_vld  [QW+1];
  side_t         dv_side [QW+1];
  logic [31:0]   dv_rem  [QW+1];
  logic [QW-1:0] dv_sh   [QW+1];
  logic [31:0]   dv_den  [QW+1];
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (adv) begin
      dv_vld[0] <= rt_vld[32];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side[0]      <= sl_in;
      dv_side[0].qneg <= sl_num[32] ^ sl_den[32];
      dv_side[0].dz   <= (sl_den == '0);
      dv_sh[0]        <= {sl_nmag[31:0], {FRAC_BITS{1'b0}}};
      dv_den[0]       <= sl_dmag[31:0];
    end
  end
  assign dv_rem[0] = '0;

  // divider chain
  for (genvar q = 0; q < QW; q++) begin : g_dv
    dtca_div_cell #(
      .QW(QW)
    ) u_div (
      .clk(clk), .rst(rst), .en(adv),
      .vld_in(dv_vld[q]), .side_in(dv_side[q]),
      .rem_in(dv_rem[q]), .sh_in(dv_sh[q]), .den_in(dv_den[q]),
      .vld_out(dv_vld[q+1]), .side_out(dv_side[q+1]),
      .rem_out(dv_rem[q+1]), .sh_out(dv_sh[q+1]), .den_out(dv_den[q+1])
    );
  end

  // output register: sign, saturation and zero divisor
  side_t         ot_side;
  logic [QW-1:0] ot_q;
  assign ot_side = dv_side[QW];
  assign ot_q    = dv_sh[QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (adv) begin
      o_vld <= dv_vld[QW];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      case (ot_side.op)
        OP_DIV, OP_SIN, OP_COS, OP_TAN, OP_COT, OP_SEC, OP_CSC: begin
          if (ot_side.dz) begin
            o_val <= '0;
            o_st  <= ST_UNDEF;
          end else if (ot_side.qneg) begin
            if (ot_q > QW'({32'd0, INT_MIN})) begin
              o_val <= INT_MIN;
              o_st  <= ST_SAT;
            end else begin
              o_val <= 32'd0 - ot_q[31:0];
              o_st  <= ST_OK;
            end
          end else begin
            if (ot_q > QW'({32'd0, INT_MAX})) begin
              o_val <= INT_MAX;
              o_st  <= ST_SAT;
            end else begin
              o_val <= ot_q[31:0];
              o_st  <= ST_OK;
            end
          end
        end
        default: begin
          o_val <= ot_side.val;
          o_st  <= ot_side.st;
        end
      endcase
    end
  end

  assign m_tvalid = o_vld;
  assign m_tdata  = o_val;
  assign m_tuser  = o_st;

endmodule

// File: hdl/dtca_mod_cell.sv
// One angle reduction cell: conditional subtract of a shifted 2*pi.
// Depends on dtca_pkg.
module dtca_mod_cell #(
  parameter logic [63:0] SUB = 64'd1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vld_in,
  input  dtca_pkg::side_t side_in,
  input  logic [63:0]     m_in,
  output logic            vld_out,
  output dtca_pkg::side_t side_out,
  output logic [63:0]     m_out
);
  import dtca_pkg::*;

  // valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  // subtract when it fits
  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      m_out    <= (m_in >= SUB) ? (m_in - SUB) : m_in;
    end
  end

endmodule

// File: hdl/dtca_rot_cell.sv
// One CORDIC rotation-mode cell, stage IDX.
// Depends on dtca_pkg.
module dtca_rot_cell #(
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               vld_in,
  input  dtca_pkg::side_t                    side_in,
  input  logic signed [dtca_pkg::XY_W-1:0]   x_in,
  input  logic signed [dtca_pkg::XY_W-1:0]   y_in,
  input  logic signed [dtca_pkg::XY_W-1:0]   z_in,
  output logic                               vld_out,
  output dtca_pkg::side_t                    side_out,
  output logic signed [dtca_pkg::XY_W-1:0]   x_out,
  output logic signed [dtca_pkg::XY_W-1:0]   y_out,
  output logic signed [dtca_pkg::XY_W-1:0]   z_out
);
  import dtca_pkg::*;

  localparam logic signed [XY_W-1:0] ANG = XY_W'(ATAN_TAB[IDX]);

  logic signed [XY_W-1:0] dx, dy;

  // floored shifts
  assign dx = y_in >>> IDX;
  assign dy = x_in >>> IDX;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  // rotate toward zero residual angle
  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      if (!z_in[XY_W-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ANG;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ANG;
      end
    end
  end

endmodule

// File: hdl/dtca_sqrt_cell.sv
// One integer square root cell, settling one result bit.
// Depends on dtca_pkg.
module dtca_sqrt_cell #(
  parameter int J = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vld_in,
  input  dtca_pkg::side_t side_in,
  input  logic [63:0]     v_in,
  input  logic [63:0]     res_in,
  output logic            vld_out,
  output dtca_pkg::side_t side_out,
  output logic [63:0]     v_out,
  output logic [63:0]     res_out
);
  import dtca_pkg::*;

  localparam logic [63:0] BITV = 64'd1 << (62 - 2 * J);

  logic [63:0] trial;

  assign trial = res_in + BITV;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  // restoring step
  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      if (v_in >= trial) begin
        v_out   <= v_in - trial;
        res_out <= (res_in >> 1) + BITV;
      end else begin
        v_out   <= v_in;
        res_out <= res_in >> 1;
      end
    end
  end

endmodule

// File: hdl/dtca_div_cell.sv
// One restoring divider cell, settling one quotient bit.
// Depends on dtca_pkg.
module dtca_div_cell #(
  parameter int QW = 48
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vld_in,
  input  dtca_pkg::side_t side_in,
  input  logic [31:0]     rem_in,
  input  logic [QW-1:0]   sh_in,
  input  logic [31:0]     den_in,
  output logic            vld_out,
  output dtca_pkg::side_t side_out,
  output logic [31:0]     rem_out,
  output logic [QW-1:0]   sh_out,
  output logic [31:0]     den_out
);
  import dtca_pkg::*;

  logic [32:0] trial, diff;
  logic        ge;

  // shift in next dividend bit, try the subtract
  assign trial = {rem_in, sh_in[QW-1]};
  assign diff  = trial - {1'b0, den_in};
  assign ge    = (trial >= {1'b0, den_in});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      den_out  <= den_in;
      rem_out  <= ge ? diff[31:0] : trial[31:0];
      sh_out   <= {sh_in[QW-2:0], ge};
    end
  end

endmodule
